// ----- rtl/trs_pkg.sv -----
package trs_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int TRIG_FRAC    = 30;
    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_W       = 34;
    localparam int Z_W          = 32;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_HALF = 34'sd536870912;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        trig_t x;
        trig_t y;
        trig_t z;
    } rot_t;

    function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 32'sh20000000;
                5'd1:  v = 32'sh12E4051E;
                5'd2:  v = 32'sh09FB385B;
                5'd3:  v = 32'sh051111D4;
                5'd4:  v = 32'sh028B0D43;
                5'd5:  v = 32'sh0145D7E1;
                5'd6:  v = 32'sh00A2F61E;
                5'd7:  v = 32'sh00517C55;
                5'd8:  v = 32'sh0028BE53;
                5'd9:  v = 32'sh00145F2F;
                5'd10: v = 32'sh000A2F98;
                5'd11: v = 32'sh000517CC;
                5'd12: v = 32'sh00028BE6;
                5'd13: v = 32'sh000145F3;
                5'd14: v = 32'sh0000A2FA;
                5'd15: v = 32'sh0000517D;
                5'd16: v = 32'sh000028BE;
                5'd17: v = 32'sh0000145F;
                5'd18: v = 32'sh00000A30;
                5'd19: v = 32'sh00000518;
                5'd20: v = 32'sh0000028C;
                5'd21: v = 32'sh00000146;
                5'd22: v = 32'sh000000A3;
                5'd23: v = 32'sh00000051;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // q4.30 product, rounded half up
    function automatic trig_t mul_trig(input trig_t a, input trig_t b);
        logic signed [2*TRIG_W-1:0] p;
        begin
            p = a * b + 68'(TRIG_HALF);
            return trig_t'(p >>> TRIG_FRAC);
        end
    endfunction

endpackage

// ----- rtl/trs_in_if.sv -----
interface trs_in_if #(
    parameter int ANGLE_BITS = trs_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = trs_pkg::COORD_BITS_DEF
);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] trans_x;
    logic signed [COORD_BITS-1:0] trans_y;
    logic signed [COORD_BITS-1:0] trans_z;
    logic [ANGLE_BITS-1:0] angle_x;
    logic [ANGLE_BITS-1:0] angle_y;
    logic [ANGLE_BITS-1:0] angle_z;
    logic signed [COORD_BITS-1:0] scale_x;
    logic signed [COORD_BITS-1:0] scale_y;
    logic signed [COORD_BITS-1:0] scale_z;

    modport source (output valid, trans_x, trans_y, trans_z, angle_x, angle_y, angle_z,
                    scale_x, scale_y, scale_z, input ready);
    modport sink (input valid, trans_x, trans_y, trans_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, output ready);
endinterface

// ----- rtl/trs_out_if.sv -----
interface trs_out_if #(
    parameter int COORD_BITS = trs_pkg::COORD_BITS_DEF
);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] elem_0;
    logic signed [COORD_BITS-1:0] elem_1;
    logic signed [COORD_BITS-1:0] elem_2;
    logic signed [COORD_BITS-1:0] elem_3;
    logic [1:0] row_index;
    logic last_row;

    modport source (output valid, elem_0, elem_1, elem_2, elem_3, row_index, last_row,
                    input ready);
    modport sink (input valid, elem_0, elem_1, elem_2, elem_3, row_index, last_row,
                  output ready);
endinterface

// ----- rtl/trs_cordic_cell.sv -----
module trs_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic clk,
    input  logic en,
    input  trs_pkg::rot_t a_in,
    input  trs_pkg::rot_t b_in,
    input  trs_pkg::rot_t c_in,
    output trs_pkg::rot_t a_out,
    output trs_pkg::rot_t b_out,
    output trs_pkg::rot_t c_out
);
    import trs_pkg::*;

    rot_t a_next, b_next, c_next;
    rot_t a_reg, b_reg, c_reg;

    function automatic rot_t step(input rot_t v);
        rot_t r;
        trig_t az;
        begin
            az = trig_t'(atan_turn(5'(STEP)));
            if (v.z >= 0)
            begin
                r.x = v.x - (v.y >>> STEP);
                r.y = v.y + (v.x >>> STEP);
                r.z = v.z - az;
            end
            else
            begin
                r.x = v.x + (v.y >>> STEP);
                r.y = v.y - (v.x >>> STEP);
                r.z = v.z + az;
            end
            return r;
        end
    endfunction

    always_comb
    begin
        a_next = step(a_in);
        b_next = step(b_in);
        c_next = step(c_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;
    assign c_out = c_reg;
endmodule

// ----- rtl/trs_scale_mul.sv -----
module trs_scale_mul #(
    parameter int COORD_BITS = trs_pkg::COORD_BITS_DEF
) (
    input  trs_pkg::trig_t r,
    input  logic signed [COORD_BITS-1:0] s,
    output logic signed [COORD_BITS-1:0] q
);
    import trs_pkg::*;

    localparam int PW = TRIG_W + COORD_BITS;
    localparam logic signed [PW-1:0] MAXV = (PW'(1) <<< (COORD_BITS-1)) - PW'(1);
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

    logic signed [PW-1:0] p, mag, rnd, v;
    logic neg;

    always_comb
    begin
        p   = PW'(r) * PW'(s);
        neg = p < 0;
        mag = neg ? -p : p;
        rnd = (mag + PW'(TRIG_HALF)) >>> TRIG_FRAC;
        v   = neg ? -rnd : rnd;
        if (v > MAXV)
            q = COORD_BITS'(MAXV);
        else if (v < MINV)
            q = COORD_BITS'(MINV);
        else
            q = COORD_BITS'(v);
    end
endmodule

// ----- rtl/trs_affine_matrix_builder_unit.sv -----
// translate-rotate-scale affine matrix builder
// in: one beat carries translation, three euler angles (binary turns) and
// three per-axis scales. out: three beats per input, rows 0..2 of
// T*Rx*Ry*Rz*S, row 3 (0,0,0,1) is implied. last_row marks row 2.
// sines and cosines come from a chain of 24 cordic cells, one per cordic
// step, each cell holding the x, y and z rotations of one item; the chain
// advances one cell per cycle whenever it moves.
// in.ready stays low after each accept until a gap counter runs down.
// products are built in registered stages; the rotation terms of one item
// sit in an output register and are scaled row by row through a shared
// scale multiplier bank of three 34x32 multipliers.
// reset clears all valid flags; pending items are dropped.
// when the receiver stalls, the output register holds, the chain behind it
// moves on until an item waits just before it, then holds, and in.ready falls.
module trs_affine_matrix_builder_unit #(
    parameter int ANGLE_BITS = trs_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = trs_pkg::COORD_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    trs_in_if.sink   in_ch,
    trs_out_if.source out_ch
);
    import trs_pkg::*;

    localparam int NCELL = CORDIC_STEPS;
    localparam int NST   = NCELL + 5;

    typedef logic signed [COORD_BITS-1:0] crd_t;
    typedef struct packed {
        crd_t tx; crd_t ty; crd_t tz;
        crd_t sx; crd_t sy; crd_t sz;
    } side_t;

    logic en;
    logic en_out;
    logic [NST-1:0] vld_reg;
    logic [1:0] row_reg;

    // output register loads when empty or when its last row leaves
    logic out_take;
    assign out_take = vld_reg[NST-1] && out_ch.ready && row_reg == 2'd2;
    assign en_out = !vld_reg[NST-1] || out_take;
    assign en = !vld_reg[NST-2] || en_out;
    // in.ready stays low after each accept until gap_reg runs down
    logic [1:0] gap_reg;
    assign in_ch.ready = en && gap_reg == 2'd0;

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            gap_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            if (en)
                vld_reg <= {en_out ? vld_reg[NST-2] : vld_reg[NST-1],
                            vld_reg[NST-3:0], acc};
            if (acc)
                gap_reg <= 2'd2;
            else if (gap_reg != 2'd0)
                gap_reg <= gap_reg - 2'd1;
            if (vld_reg[NST-1] && out_ch.ready)
                row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
        end
    end

    // angle fold into cordic seed
    function automatic rot_t seed(input logic [ANGLE_BITS-1:0] a);
        rot_t r;
        logic [31:0] turn;
        begin
            turn = 32'(a) << (32 - ANGLE_BITS);
            r.x = CORDIC_GAIN_INV;
            r.y = '0;
            r.z = trig_t'({2'b00, turn[29:0]});
            return r;
        end
    endfunction

    rot_t ca [NCELL+1];
    rot_t cb [NCELL+1];
    rot_t cc [NCELL+1];
    assign ca[0] = seed(in_ch.angle_x);
    assign cb[0] = seed(in_ch.angle_y);
    assign cc[0] = seed(in_ch.angle_z);

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            trs_cordic_cell #(.STEP(g)) u_cell (
                .clk(clk), .en(en),
                .a_in(ca[g]), .b_in(cb[g]), .c_in(cc[g]),
                .a_out(ca[g+1]), .b_out(cb[g+1]), .c_out(cc[g+1])
            );
        end
    endgenerate

    // side data and quadrants travel with the chain
    side_t side_reg [NST];
    logic [5:0] quad_reg [NCELL];
    side_t side_in;
    assign side_in = '{in_ch.trans_x, in_ch.trans_y, in_ch.trans_z,
                       in_ch.scale_x, in_ch.scale_y, in_ch.scale_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NST-1; k++)
                side_reg[k] <= side_reg[k-1];
            quad_reg[0] <= {in_ch.angle_x[ANGLE_BITS-1 -: 2],
                            in_ch.angle_y[ANGLE_BITS-1 -: 2],
                            in_ch.angle_z[ANGLE_BITS-1 -: 2]};
            for (int k = 1; k < NCELL; k++)
                quad_reg[k] <= quad_reg[k-1];
        end
        if (en_out)
            side_reg[NST-1] <= side_reg[NST-2];
    end

    function automatic void unfold(input rot_t v, input logic [1:0] q,
                                   output trig_t c, output trig_t s);
        begin
            case (q)
                2'd0: begin c = v.x;  s = v.y;  end
                2'd1: begin c = -v.y; s = v.x;  end
                2'd2: begin c = -v.x; s = -v.y; end
                default: begin c = v.y; s = -v.x; end
            endcase
        end
    endfunction

    // stage 1: sin/cos registered
    trig_t cx_reg, sx_reg, cy_reg, sy_reg, cz_reg, sz_reg;
    trig_t cx_n, sx_n, cy_n, sy_n, cz_n, sz_n;
    always_comb
    begin
        unfold(ca[NCELL], quad_reg[NCELL-1][5:4], cx_n, sx_n);
        unfold(cb[NCELL], quad_reg[NCELL-1][3:2], cy_n, sy_n);
        unfold(cc[NCELL], quad_reg[NCELL-1][1:0], cz_n, sz_n);
    end

    // stage 2: first products
    trig_t sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sxcy_reg, cxcy_reg;
    trig_t cx2_reg, sx2_reg, cz2_reg, sz2_reg, sy2_reg;
    // stage 3: second products
    trig_t p_reg [12];
    trig_t cxcy_hold_reg;
    // stage 4: rotation terms
    trig_t r_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= cx_n; sx_reg <= sx_n; cy_reg <= cy_n;
            sy_reg <= sy_n; cz_reg <= cz_n; sz_reg <= sz_n;

            sxsy_reg <= mul_trig(sx_reg, sy_reg);
            cxsy_reg <= mul_trig(cx_reg, sy_reg);
            cycz_reg <= mul_trig(cy_reg, cz_reg);
            cysz_reg <= mul_trig(cy_reg, sz_reg);
            sxcy_reg <= mul_trig(sx_reg, cy_reg);
            cxcy_reg <= mul_trig(cx_reg, cy_reg);
            cx2_reg <= cx_reg; sx2_reg <= sx_reg;
            cz2_reg <= cz_reg; sz2_reg <= sz_reg; sy2_reg <= sy_reg;

            p_reg[0]  <= cycz_reg;
            p_reg[1]  <= -cysz_reg;
            p_reg[2]  <= sy2_reg;
            p_reg[3]  <= mul_trig(sxsy_reg, cz2_reg);
            p_reg[4]  <= mul_trig(cx2_reg, sz2_reg);
            p_reg[5]  <= mul_trig(sxsy_reg, sz2_reg);
            p_reg[6]  <= mul_trig(cx2_reg, cz2_reg);
            p_reg[7]  <= -sxcy_reg;
            p_reg[8]  <= mul_trig(cxsy_reg, cz2_reg);
            p_reg[9]  <= mul_trig(sx2_reg, sz2_reg);
            p_reg[10] <= mul_trig(cxsy_reg, sz2_reg);
            p_reg[11] <= mul_trig(sx2_reg, cz2_reg);

            r_reg[0] <= p_reg[0];
            r_reg[1] <= p_reg[1];
            r_reg[2] <= p_reg[2];
            r_reg[3] <= p_reg[3] + p_reg[4];
            r_reg[4] <= p_reg[6] - p_reg[5];
            r_reg[5] <= p_reg[7];
            r_reg[6] <= p_reg[9] - p_reg[8];
            r_reg[7] <= p_reg[10] + p_reg[11];
            r_reg[8] <= cxcy_hold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cxcy_hold_reg <= cxcy_reg;
    end

    // stage 5: rows held for output, scaled row by row
    trig_t rh_reg [9];
    always_ff @(posedge clk)
    begin
        if (en_out)
            for (int k = 0; k < 9; k++)
                rh_reg[k] <= r_reg[k];
    end

    side_t sd;
    assign sd = side_reg[NST-1];

    trig_t r0, r1, r2;
    crd_t t_sel;
    always_comb
    begin
        case (row_reg)
            2'd0:    begin r0 = rh_reg[0]; r1 = rh_reg[1]; r2 = rh_reg[2]; t_sel = sd.tx; end
            2'd1:    begin r0 = rh_reg[3]; r1 = rh_reg[4]; r2 = rh_reg[5]; t_sel = sd.ty; end
            default: begin r0 = rh_reg[6]; r1 = rh_reg[7]; r2 = rh_reg[8]; t_sel = sd.tz; end
        endcase
    end

    trs_scale_mul #(.COORD_BITS(COORD_BITS)) u_m0 (.r(r0), .s(sd.sx), .q(out_ch.elem_0));
    trs_scale_mul #(.COORD_BITS(COORD_BITS)) u_m1 (.r(r1), .s(sd.sy), .q(out_ch.elem_1));
    trs_scale_mul #(.COORD_BITS(COORD_BITS)) u_m2 (.r(r2), .s(sd.sz), .q(out_ch.elem_2));

    assign out_ch.elem_3    = t_sel;
    assign out_ch.valid     = vld_reg[NST-1];
    assign out_ch.row_index = row_reg;
    assign out_ch.last_row  = row_reg == 2'd2;
endmodule

// ----- rtl/trs_checker.sv -----
module trs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] row_index,
    input logic last_row
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == (row_index == 2'd2)))
        else $error("last_row mismatch");

    a_row_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_index != 2'd3)
        else $error("row_index out of range");

    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_row) |=> (out_valid &&
            row_index == $past(row_index) + 2'd1))
        else $error("row sequence broken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(row_index)))
        else $error("output dropped under stall");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted too fast");
endmodule

bind trs_affine_matrix_builder_unit trs_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .row_index(out_ch.row_index), .last_row(out_ch.last_row)
);
